// ===== rtl/aes_pkg.sv =====
// AES-128 package: payload structs, S-box tables, GF helpers and round functions.
// Used by aes_key_sched and the top level aes128_block_cipher.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int RoundsDefault = 10;
    localparam int CfgIdxW       = 1;
    localparam int CfgDataW      = 64;
    localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'd0;
    localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'd1;
    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;
    localparam logic [7:0] GfPoly = 8'h1B;

    typedef struct packed {
        logic        command;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    typedef logic [127:0] state_t;

    localparam logic [7:0] FWD_SB [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SB [256] = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
    endfunction

    function automatic logic [7:0] byte_at(input state_t s, input int i);
        byte_at = s[127-8*i -: 8];
    endfunction

    function automatic state_t byte_subst(input state_t s, input logic inv);
        state_t o;
        logic [7:0] b;
        o = '0;
        for (int i = 0; i < 16; i++)
        begin
            b = byte_at(s, i);
            o[127-8*i -: 8] = inv ? INV_SB[b] : FWD_SB[b];
        end
        byte_subst = o;
    endfunction

    function automatic state_t row_rotate(input state_t s, input logic inv);
        state_t o;
        int src;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                o[127-8*(4*c+r) -: 8] = byte_at(s, 4*src + r);
            end
        end
        row_rotate = o;
    endfunction

    function automatic state_t mix_cols(input state_t s, input logic inv);
        state_t o;
        logic [7:0] a0, a1, a2, a3, u, v, t;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = byte_at(s, 4*c);
            a1 = byte_at(s, 4*c+1);
            a2 = byte_at(s, 4*c+2);
            a3 = byte_at(s, 4*c+3);
            if (inv)
            begin
                u = gf_dbl(gf_dbl(a0 ^ a2));
                v = gf_dbl(gf_dbl(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            t = a0 ^ a1 ^ a2 ^ a3;
            o[127-32*c -: 32] = {a0 ^ t ^ gf_dbl(a0 ^ a1), a1 ^ t ^ gf_dbl(a1 ^ a2),
                                 a2 ^ t ^ gf_dbl(a2 ^ a3), a3 ^ t ^ gf_dbl(a3 ^ a0)};
        end
        mix_cols = o;
    endfunction

endpackage

// ===== rtl/aes128_block_cipher.sv =====
// AES-128 top level: config port, key schedule and unrolled round pipeline.
// Depends on aes_pkg and aes_key_sched.
`timescale 1ns / 1ps
// One block enters per cycle unless in_stall is high, and passes through the stages:
// one stage for the initial key add and one per round.
// A stall of a valid output item freezes the whole pipeline. After reset and after a key write, the input
// stalls until the round keys have settled through the key schedule chain, so every
// block that follows a key write uses the new key.
module aes128_block_cipher
    import aes_pkg::*;
#(
    parameter int ROUNDS = RoundsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item
);

    localparam int SettleW = $clog2(ROUNDS + 2);

    logic [63:0] key_high_reg, key_low_reg;
    state_t      rkey [ROUNDS+1];
    logic [SettleW-1:0] settle_reg;

    logic        vld_reg [ROUNDS+1];
    logic        cmd_reg [ROUNDS+1];
    state_t      st_reg  [ROUNDS+1];
    logic        advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                RegKeyHigh: key_high_reg <= cfg_data;
                RegKeyLow:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold the input until the round keys match the key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SettleW'(ROUNDS + 1);
        else if (cfg_write)
            settle_reg <= SettleW'(ROUNDS + 1);
        else if (settle_reg != '0)
            settle_reg <= settle_reg - 1'b1;
    end

    aes_key_sched #(.ROUNDS(ROUNDS)) u_key_sched
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .rkey      (rkey)
    );

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance || cfg_write || (settle_reg != '0);

    function automatic state_t do_round(input state_t s, input logic inv,
                                        input state_t k, input logic last);
        state_t x;
        if (!inv)
        begin
            x = row_rotate(byte_subst(s, 1'b0), 1'b0);
            if (!last)
                x = mix_cols(x, 1'b0);
            do_round = x ^ k;
        end
        else
        begin
            x = byte_subst(row_rotate(s, 1'b1), 1'b1) ^ k;
            if (!last)
                x = mix_cols(x, 1'b1);
            do_round = x;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ROUNDS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid && !in_stall;
            for (int i = 1; i <= ROUNDS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg[0] <= in_item.command;
            st_reg[0]  <= {in_item.block_high, in_item.block_low} ^
                          (in_item.command == CmdDecrypt ? rkey[ROUNDS] : rkey[0]);
            for (int i = 1; i <= ROUNDS; i++)
            begin
                cmd_reg[i] <= cmd_reg[i-1];
                st_reg[i]  <= do_round(st_reg[i-1], cmd_reg[i-1] == CmdDecrypt,
                                       cmd_reg[i-1] == CmdDecrypt ? rkey[ROUNDS-i]
                                                                  : rkey[i],
                                       i == ROUNDS);
            end
        end
    end

    assign out_valid = vld_reg[ROUNDS];
    assign out_item  = '{result_high: st_reg[ROUNDS][127:64],
                         result_low:  st_reg[ROUNDS][63:0]};

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed under stall");
    a_in_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        ((out_valid && out_stall) || (settle_reg != '0)) |-> in_stall)
        else $error("input not stalled while output stalled or keys settling");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted item lost at stage 0");

endmodule

// ===== rtl/aes_key_sched.sv =====
// AES-128 key expansion: registered round keys derived one round per cycle.
// Depends on aes_pkg for the S-box and GF doubling.
`timescale 1ns / 1ps
module aes_key_sched
    import aes_pkg::*;
#(
    parameter int ROUNDS = RoundsDefault
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [127:0]   key,
    output state_t         rkey [ROUNDS+1]
);

    state_t     rk_reg [ROUNDS+1];
    logic [7:0] rcon   [ROUNDS+1];

    always_comb
    begin
        rcon[0] = 8'h00;
        rcon[1] = 8'h01;
        for (int r = 2; r <= ROUNDS; r++)
            rcon[r] = gf_dbl(rcon[r-1]);
    end

    function automatic state_t next_key(input state_t p, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t = {FWD_SB[p[23:16]] ^ rc, FWD_SB[p[15:8]], FWD_SB[p[7:0]], FWD_SB[p[31:24]]};
        w0 = p[127:96] ^ t;
        w1 = p[95:64] ^ w0;
        w2 = p[63:32] ^ w1;
        w3 = p[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= ROUNDS; r++)
                rk_reg[r] <= '0;
        end
        else
        begin
            rk_reg[0] <= key;
            for (int r = 1; r <= ROUNDS; r++)
                rk_reg[r] <= next_key(rk_reg[r-1], rcon[r]);
        end
    end

    assign rkey = rk_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for aes128_block_cipher: encrypt and decrypt items checked
// against an in-bench AES-128 predictor. Depends on aes_pkg and the cipher RTL.
`timescale 1ns / 1ps
module testbench;
    import aes_pkg::*;

    localparam int LATENCY = 12;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_item;
    logic                out_valid;
    logic                out_stall;
    out_item_t           out_item;

    aes128_block_cipher dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    logic [63:0] cipher_key_high;
    logic [63:0] cipher_key_low;
    in_item_t    pending_blocks[$];
    out_item_t   expected_blocks[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          errors;

    logic [7:0] sbox_fwd [256];
    logic [7:0] sbox_inv [256];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic out_item_t aes_transform(input in_item_t it, input logic [63:0] kh,
                                                input logic [63:0] kl);
        logic [7:0] rk [11][16];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, u, v, x;
        int         src;
        out_item_t  o;
        for (int i = 0; i < 8; i++)
        begin
            rk[0][i]   = kh[63-8*i -: 8];
            rk[0][8+i] = kl[63-8*i -: 8];
            s[i]       = it.block_high[63-8*i -: 8];
            s[8+i]     = it.block_low[63-8*i -: 8];
        end
        rc = 8'h01;
        for (int r = 1; r <= 10; r++)
        begin
            w[0] = sbox_fwd[rk[r-1][13]] ^ rc;
            w[1] = sbox_fwd[rk[r-1][14]];
            w[2] = sbox_fwd[rk[r-1][15]];
            w[3] = sbox_fwd[rk[r-1][12]];
            for (int j = 0; j < 4; j++)
                rk[r][j] = rk[r-1][j] ^ w[j];
            for (int j = 4; j < 16; j++)
                rk[r][j] = rk[r-1][j] ^ rk[r][j-4];
            rc = xtime(rc);
        end
        for (int i = 0; i < 16; i++)
            s[i] ^= rk[it.command == CmdEncrypt ? 0 : 10][i];
        for (int step = 1; step <= 10; step++)
        begin
            if (it.command == CmdEncrypt)
            begin
                for (int i = 0; i < 16; i++)
                    s[i] = sbox_fwd[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*c+r] = s[4*((c+r)&3)+r];
                s = t;
                if (step < 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        x = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
                        s[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
                        s[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
                        s[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++)
                    s[i] ^= rk[step][i];
            end
            else
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        src = (c + 4 - r) & 3;
                        t[4*c+r] = s[4*src+r];
                    end
                for (int i = 0; i < 16; i++)
                    s[i] = sbox_inv[t[i]] ^ rk[10-step][i];
                if (step < 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        u = xtime(xtime(a0 ^ a2));
                        v = xtime(xtime(a1 ^ a3));
                        a0 ^= u; a1 ^= v; a2 ^= u; a3 ^= v;
                        x = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
                        s[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
                        s[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
                        s[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            o.result_high[63-8*i -: 8] = s[i];
            o.result_low[63-8*i -: 8]  = s[8+i];
        end
        aes_transform = o;
    endfunction

    function automatic logic [63:0] rand64();
        rand64 = {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 7))
            0: edge64 = '0;
            1: edge64 = '1;
            2: edge64 = 64'h8000_0000_0000_0000;
            3: edge64 = 64'h0000_0000_0000_0001;
            default: edge64 = rand64();
        endcase
    endfunction

    task automatic write_key(input logic [63:0] kh, input logic [63:0] kl);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= RegKeyHigh;
        cfg_data  <= kh;
        @(posedge clk);
        cfg_index <= RegKeyLow;
        cfg_data  <= kl;
        @(posedge clk);
        cfg_write <= 1'b0;
        cipher_key_high = kh;
        cipher_key_low  = kl;
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0 || expected_blocks.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic queue_block(input logic cmd, input logic [63:0] bh, input logic [63:0] bl);
        in_item_t it;
        it.command    = cmd;
        it.block_high = bh;
        it.block_low  = bl;
        pending_blocks.push_back(it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_blocks.push_back(aes_transform(in_item, cipher_key_high,
                                                        cipher_key_low));
                void'(pending_blocks.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_blocks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_blocks[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("unexpected item %h", out_item);
                    errors++;
                end
                else
                begin
                    exp_item = expected_blocks.pop_front();
                    if (out_item.result_high !== exp_item.result_high)
                    begin
                        $error("result_high expected %h actual %h",
                               exp_item.result_high, out_item.result_high);
                        errors++;
                    end
                    if (out_item.result_low !== exp_item.result_low)
                    begin
                        $error("result_low expected %h actual %h",
                               exp_item.result_low, out_item.result_low);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [63:0] kh, kl;
        in_item_t    it;
        for (int i = 0; i < 256; i++)
        begin
            sbox_fwd[i] = FWD_SB[i];
            sbox_inv[FWD_SB[i]] = i[7:0];
        end
        errors          = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_cycles     = 0;
        cipher_key_high = '0;
        cipher_key_low  = '0;
        cfg_write = 1'b0;
        cfg_index = RegKeyHigh;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (LATENCY + 2) @(posedge clk);

        // reset key, then standard vector key, then all-ones key
        queue_block(CmdEncrypt, '0, '0);
        queue_block(CmdDecrypt, '0, '0);
        queue_block(CmdEncrypt, '1, '1);
        queue_block(CmdDecrypt, '1, '1);
        drain();
        write_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        queue_block(CmdEncrypt, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        queue_block(CmdDecrypt, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
        queue_block(CmdEncrypt, 64'h8000_0000_0000_0000, 64'h1);
        queue_block(CmdDecrypt, 64'h8000_0000_0000_0000, 64'h1);
        drain();
        write_key('1, '1);
        queue_block(CmdEncrypt, '0, '1);
        queue_block(CmdDecrypt, '1, '0);
        queue_block(CmdEncrypt, '1, '1);
        queue_block(CmdDecrypt, '0, '0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: begin send_idle_pct = 30; recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            kh = edge64();
            kl = edge64();
            write_key(kh, kl);
            if (phase == 2)
                hold_cycles = 200;
            for (int n = 0; n < 250; n++)
            begin
                it.command    = 1'($urandom_range(0, 1));
                it.block_high = ($urandom_range(0, 15) == 0) ? edge64() : rand64();
                it.block_low  = ($urandom_range(0, 15) == 0) ? edge64() : rand64();
                pending_blocks.push_back(it);
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
